>>> sv/pid_controller_integral_clamp_core_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef PID_CONTROLLER_INTEGRAL_CLAMP_CORE_MACROS_SVH
`define PID_CONTROLLER_INTEGRAL_CLAMP_CORE_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define PIDIC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define PIDIC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pidic_pkg.sv
`default_nettype none

package pidic_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int TIME_W    = 24;
   localparam int LIMIT_W   = 47;
   localparam int INTEG_W   = 48;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = LIMIT_W;

   localparam int MUL_W     = 32;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int QUO_W     = DIFF_W + FRAC_BITS;
   localparam int ACC_W     = QUO_W + MUL_W;
   localparam int SHR_W     = ACC_W - FRAC_BITS;
   localparam int CAP_EXP   = 60;
   localparam int TERM_W    = CAP_EXP + 2;
   localparam int SUM_W     = TERM_W + 1;
   localparam int DIV_CNT_W = $clog2(QUO_W + 1);

   localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << CAP_EXP;
   localparam logic signed [DATA_W-1:0] GAIN_ONE = DATA_W'(1) << FRAC_BITS;
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN      = 3'd0,
      REG_INTEG_GAIN     = 3'd1,
      REG_DERIV_GAIN     = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_SETPOINT       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]       integral_limit;
      logic signed [DATA_W-1:0] setpoint;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             clear;
      logic             high;
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic              start;
      logic [QUO_W-1:0]  dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [DATA_W-1:0] mag_data(input logic signed [DATA_W-1:0] x);
      return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
   endfunction

   function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] x);
      return x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
   endfunction

   function automatic logic [INTEG_W-1:0] mag_integ(input logic signed [INTEG_W-1:0] x);
      return x[INTEG_W-1] ? INTEG_W'(-x) : INTEG_W'(x);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_err(input logic signed [DIFF_W-1:0] x);
      if (x[DIFF_W-1] != x[DATA_W-1]) begin
         return x[DIFF_W-1] ? DATA_MIN : DATA_MAX;
      end
      return x[DATA_W-1:0];
   endfunction

   function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [TERM_W-1:0] x);
      if ((&x[TERM_W-1:INTEG_W-1]) || !(|x[TERM_W-1:INTEG_W-1])) begin
         return x[INTEG_W-1:0];
      end
      return x[TERM_W-1] ? INTEG_MIN : INTEG_MAX;
   endfunction

   // Drop the fraction bits, cap the magnitude, then apply the sign.
   function automatic logic signed [TERM_W-1:0] term_of(input logic [ACC_W-1:0] acc,
                                                        input logic neg);
      logic [SHR_W-1:0]  m;
      logic [TERM_W-1:0] c;
      m = acc[ACC_W-1:FRAC_BITS];
      if (m > SHR_W'(TERM_CAP)) begin
         c = TERM_CAP;
      end else begin
         c = TERM_W'(m);
      end
      return neg ? -signed'(c) : signed'(c);
   endfunction

endpackage

`default_nettype wire

>>> sv/pidic_mul.sv
`default_nettype none

module pidic_mul import pidic_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mul_req_type      mul_req,
   output logic [ACC_W-1:0]      mul_acc
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              valid_ff, clear_ff, high_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  addend;

   assign prod_in = PROD_W'(mul_req.op_a) * PROD_W'(mul_req.op_b);
   assign addend  = high_ff ? (ACC_W'(prod_ff) << MUL_W) : ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (valid_ff) begin
         acc_in = (clear_ff ? '0 : acc_ff) + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         clear_ff <= 1'b0;
         high_ff  <= 1'b0;
      end else begin
         valid_ff <= mul_req.valid;
         clear_ff <= mul_req.clear;
         high_ff  <= mul_req.high;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign mul_acc = acc_ff;

endmodule

`default_nettype wire

>>> sv/pidic_div.sv
`default_nettype none

module pidic_div import pidic_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [TIME_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TIME_W:0]      shifted;
   logic [TIME_W+1:0]    trial;

   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(QUO_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // restoring step: one quotient bit per cycle, MSB first
         if (trial[TIME_W+1]) begin
            rem_in = shifted[TIME_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end else begin
            rem_in = trial[TIME_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/pidic_ctrl.sv
`default_nettype none

module pidic_ctrl import pidic_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_measured_value,
   input  wire logic [TIME_W-1:0]        req_elapsed_time,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_drive_value,
   output logic                          rsp_output_saturated,
   output logic                          rsp_derivative_skipped,
   output mul_req_type                   mul_req,
   input  wire logic [ACC_W-1:0]         mul_acc,
   output div_req_type                   div_req,
   input  wire div_rsp_type              div_rsp
);

   typedef enum logic [20:0] {
      S_IDLE     = 21'b000000000000000000001,
      S_ERR      = 21'b000000000000000000010,
      S_P_ISS    = 21'b000000000000000000100,
      S_P_WAIT   = 21'b000000000000000001000,
      S_P_TAKE   = 21'b000000000000000010000,
      S_INC_WAIT = 21'b000000000000000100000,
      S_INC_TAKE = 21'b000000000000001000000,
      S_MAG      = 21'b000000000000010000000,
      S_CLAMP    = 21'b000000000000100000000,
      S_I_LO     = 21'b000000000001000000000,
      S_I_HI     = 21'b000000000010000000000,
      S_I_WAIT   = 21'b000000000100000000000,
      S_I_TAKE   = 21'b000000001000000000000,
      S_DIV_WAIT = 21'b000000010000000000000,
      S_D_LO     = 21'b000000100000000000000,
      S_D_HI     = 21'b000001000000000000000,
      S_D_WAIT   = 21'b000010000000000000000,
      S_D_TAKE   = 21'b000100000000000000000,
      S_SUM1     = 21'b001000000000000000000,
      S_SUM2     = 21'b010000000000000000000,
      S_DONE     = 21'b100000000000000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [DATA_W-1:0]   meas_ff, meas_in;
   logic [TIME_W-1:0]          dt_ff, dt_in;
   logic signed [DATA_W-1:0]   err_ff, err_in;
   logic signed [DATA_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic [INTEG_W-1:0]         imag_ff, imag_in;
   logic                       dneg_ff, dneg_in;
   logic signed [TERM_W-1:0]   p_ff, p_in;
   logic signed [TERM_W-1:0]   i_ff, i_in;
   logic signed [TERM_W-1:0]   d_ff, d_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]   drive_ff, drive_in;
   logic                       sat_ff, sat_in;
   logic                       skip_ff, skip_in;

   logic signed [DIFF_W-1:0]   raw_err;
   logic signed [DIFF_W-1:0]   err_diff;
   logic                       dt_zero;
   logic                       sum_fits;
   logic [INTEG_W-1:0]         limit_ext;

   assign raw_err   = DIFF_W'(cfg.setpoint) - DIFF_W'(meas_ff);
   assign err_diff  = DIFF_W'(err_ff) - DIFF_W'(prev_err_ff);
   assign dt_zero   = (dt_ff == '0);
   assign limit_ext = INTEG_W'(cfg.integral_limit);
   assign sum_fits  = (&sum_ff[SUM_W-1:DATA_W-1]) || !(|sum_ff[SUM_W-1:DATA_W-1]);

   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      err_in       = err_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      imag_in      = imag_ff;
      dneg_in      = dneg_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      drive_in     = drive_ff;
      sat_in       = sat_ff;
      skip_in      = skip_ff;
      mul_req      = '0;
      div_req      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               meas_in  = req_measured_value;
               dt_in    = req_elapsed_time;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            err_in   = sat_err(raw_err);
            state_in = S_P_ISS;
         end
         S_P_ISS: begin
            mul_req.valid = 1'b1;
            mul_req.clear = 1'b1;
            mul_req.op_a  = mag_data(cfg.prop_gain);
            mul_req.op_b  = mag_data(err_ff);
            // derivative quotient runs alongside the multiplies
            div_req.start    = !dt_zero;
            div_req.dividend = {mag_diff(err_diff), {FRAC_BITS{1'b0}}};
            div_req.divisor  = dt_ff;
            dneg_in     = err_diff[DIFF_W-1] ^ cfg.deriv_gain[DATA_W-1];
            prev_err_in = err_ff;
            d_in        = '0;
            state_in    = S_P_WAIT;
         end
         S_P_WAIT: begin
            state_in = S_P_TAKE;
         end
         S_P_TAKE: begin
            p_in          = term_of(mul_acc, cfg.prop_gain[DATA_W-1] ^ err_ff[DATA_W-1]);
            mul_req.valid = 1'b1;
            mul_req.clear = 1'b1;
            mul_req.op_a  = mag_data(err_ff);
            mul_req.op_b  = MUL_W'(dt_ff);
            state_in      = S_INC_WAIT;
         end
         S_INC_WAIT: begin
            state_in = S_INC_TAKE;
         end
         S_INC_TAKE: begin
            integ_in = sat_integ(TERM_W'(integ_ff) + term_of(mul_acc, err_ff[DATA_W-1]));
            state_in = S_MAG;
         end
         S_MAG: begin
            imag_in  = mag_integ(integ_ff);
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if ((cfg.integ_gain != '0) && (cfg.integral_limit != '0) &&
                (imag_ff > limit_ext)) begin
               integ_in = integ_ff[INTEG_W-1] ? -signed'(limit_ext) : signed'(limit_ext);
               imag_in  = limit_ext;
            end
            state_in = S_I_LO;
         end
         S_I_LO: begin
            mul_req.valid = 1'b1;
            mul_req.clear = 1'b1;
            mul_req.op_a  = mag_data(cfg.integ_gain);
            mul_req.op_b  = imag_ff[MUL_W-1:0];
            state_in      = S_I_HI;
         end
         S_I_HI: begin
            mul_req.valid = 1'b1;
            mul_req.high  = 1'b1;
            mul_req.op_a  = mag_data(cfg.integ_gain);
            mul_req.op_b  = MUL_W'(imag_ff[INTEG_W-1:MUL_W]);
            state_in      = S_I_WAIT;
         end
         S_I_WAIT: begin
            state_in = S_I_TAKE;
         end
         S_I_TAKE: begin
            i_in = term_of(mul_acc, cfg.integ_gain[DATA_W-1] ^ integ_ff[INTEG_W-1]);
            if (dt_zero) begin
               state_in = S_SUM1;
            end else begin
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_D_LO;
            end
         end
         S_D_LO: begin
            mul_req.valid = 1'b1;
            mul_req.clear = 1'b1;
            mul_req.op_a  = mag_data(cfg.deriv_gain);
            mul_req.op_b  = div_rsp.quotient[MUL_W-1:0];
            state_in      = S_D_HI;
         end
         S_D_HI: begin
            mul_req.valid = 1'b1;
            mul_req.high  = 1'b1;
            mul_req.op_a  = mag_data(cfg.deriv_gain);
            mul_req.op_b  = MUL_W'(div_rsp.quotient[QUO_W-1:MUL_W]);
            state_in      = S_D_WAIT;
         end
         S_D_WAIT: begin
            state_in = S_D_TAKE;
         end
         S_D_TAKE: begin
            d_in     = term_of(mul_acc, dneg_ff);
            state_in = S_SUM1;
         end
         S_SUM1: begin
            sum_in   = SUM_W'(p_ff) + SUM_W'(i_ff);
            state_in = S_SUM2;
         end
         S_SUM2: begin
            sum_in   = sum_ff + SUM_W'(d_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               sat_in       = !sum_fits;
               skip_in      = dt_zero;
               if (sum_fits) begin
                  drive_in = sum_ff[DATA_W-1:0];
               end else begin
                  drive_in = sum_ff[SUM_W-1] ? DATA_MIN : DATA_MAX;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_err_ff  <= prev_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      meas_ff  <= meas_in;
      dt_ff    <= dt_in;
      err_ff   <= err_in;
      imag_ff  <= imag_in;
      dneg_ff  <= dneg_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      d_ff     <= d_in;
      sum_ff   <= sum_in;
      drive_ff <= drive_in;
      sat_ff   <= sat_in;
      skip_ff  <= skip_in;
   end

   assign req_ready              = (state_ff == S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_drive_value        = drive_ff;
   assign rsp_output_saturated   = sat_ff;
   assign rsp_derivative_skipped = skip_ff;

endmodule

`default_nettype wire

>>> sv/pid_controller_integral_clamp_core.sv
// PID controller with a clamped integral, signed Q15.16 data.
// Request channel (req_*): one measurement and the elapsed time since the
// previous update. Response channel (rsp_*): the saturated drive value with
// flags for output clipping and for a skipped derivative (zero elapsed time).
// Both channels use valid/ready; an item moves when valid and ready are high.
// Control registers are written through csr_* (index, data), always ready;
// write them only while no request is in flight.
// A new request can be accepted in the cycle after the previous result is
// loaded, so the block takes one request at a time.
// The serial divider for the derivative quotient retires one quotient bit
// per cycle over 49 bits; one shared 32x32 multiplier forms the products in
// one or two partial products each.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, that next request completes its arithmetic
// and holds in its last step until the output register frees up.
// Reset (synchronous, active high) clears the integral and previous error,
// sets all gains to 1.0, the limit (no clamp) and the setpoint to zero.
`default_nettype none

module pid_controller_integral_clamp_core import pidic_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_measured_value,
   input  wire logic [TIME_W-1:0]        req_elapsed_time,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_drive_value,
   output logic                          rsp_output_saturated,
   output logic                          rsp_derivative_skipped,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_W-1:0]         csr_data
);

   cfg_type          cfg_ff, cfg_in;
   mul_req_type      mul_req;
   logic [ACC_W-1:0] mul_acc;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PROP_GAIN:      cfg_in.prop_gain      = csr_data[DATA_W-1:0];
            REG_INTEG_GAIN:     cfg_in.integ_gain     = csr_data[DATA_W-1:0];
            REG_DERIV_GAIN:     cfg_in.deriv_gain     = csr_data[DATA_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_data[LIMIT_W-1:0];
            REG_SETPOINT:       cfg_in.setpoint       = csr_data[DATA_W-1:0];
            default: begin
               // drop writes to unmapped indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= GAIN_ONE;
         cfg_ff.integ_gain     <= GAIN_ONE;
         cfg_ff.deriv_gain     <= GAIN_ONE;
         cfg_ff.integral_limit <= '0;
         cfg_ff.setpoint       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pidic_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_acc (mul_acc)
   );

   pidic_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pidic_ctrl u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_measured_value     (req_measured_value),
      .req_elapsed_time       (req_elapsed_time),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_drive_value        (rsp_drive_value),
      .rsp_output_saturated   (rsp_output_saturated),
      .rsp_derivative_skipped (rsp_derivative_skipped),
      .mul_req                (mul_req),
      .mul_acc                (mul_acc),
      .div_req                (div_req),
      .div_rsp                (div_rsp)
   );

endmodule

`default_nettype wire

>>> sv/pidic_checker.sv
`default_nettype none
`include "pid_controller_integral_clamp_core_macros.svh"

module pidic_checker import pidic_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_drive_value,
   input wire logic                     rsp_output_saturated,
   input wire logic                     rsp_derivative_skipped
);

   logic [DATA_W+1:0] rsp_payload;

   assign rsp_payload = {rsp_drive_value, rsp_output_saturated, rsp_derivative_skipped};

   // a stalled response keeps its payload
   `PIDIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                      rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // one request at a time: busy right after acceptance
   `PIDIC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready,
                      "request accepted while busy")

   // no result can appear the cycle after a request is taken
   `PIDIC_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready,
                      !$rose(rsp_valid), "response too early")

   // a clipped drive sits at a range limit
   `PIDIC_ASSERT_SAME(a_sat_at_limit, clock, reset, rsp_valid && rsp_output_saturated,
                      rsp_drive_value == DATA_MAX || rsp_drive_value == DATA_MIN,
                      "saturated drive not at limit")

   // nothing to deliver right after reset
   `PIDIC_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid,
                      "response valid after reset")

endmodule

bind pid_controller_integral_clamp_core pidic_checker u_pidic_checker (.*);

`default_nettype wire
